// ===== sv/xtkb_pkg.sv =====
// ----------------------------------------------------------------------------
// xtkb_pkg
// Shared types and codes for the XT keyboard device transmitter.
// ----------------------------------------------------------------------------
package xtkb_pkg;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_EDGE = 2'd1;
    localparam logic [1:0] OP_PUSH = 2'd2;

    localparam logic [1:0] TMR_KEEP    = 2'd0;
    localparam logic [1:0] TMR_RESTART = 2'd1;
    localparam logic [1:0] TMR_STOP    = 2'd2;

    localparam logic [1:0] WATCH_KEEP    = 2'd0;
    localparam logic [1:0] WATCH_OFF     = 2'd1;
    localparam logic [1:0] WATCH_RISING  = 2'd2;
    localparam logic [1:0] WATCH_FALLING = 2'd3;

    localparam logic [7:0] HOLD_TICKS_MAX = 8'd254;
    localparam logic [7:0] HOLDOFF_US     = 8'd100;
    localparam logic [7:0] RESET_REPLY    = 8'hAA;
    localparam logic [3:0] FRAME_BITS     = 4'd8;

    localparam logic [7:0] HALF_CYCLE_RESET = 8'd50;
    localparam logic [7:0] HOLD_CFG_RESET   = 8'd60;

    localparam logic REG_HALF_CYCLE = 1'b0;
    localparam logic REG_HOLD_TICKS = 1'b1;

    typedef struct packed {
        logic       enq;
        logic [7:0] enq_byte;
        logic       deq;
    } xtkb_qreq_t;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic       last;
        logic [7:0] head;
    } xtkb_qstat_t;

    typedef struct packed {
        logic       queue_empty;
        logic       push_accepted;
        logic [1:0] clk_watch;
        logic [7:0] timer_us;
        logic [1:0] timer_cmd;
        logic       data_level;
        logic       clk_level;
    } xtkb_result_t;

endpackage

// ===== sv/xtkb_queue.sv =====
// ----------------------------------------------------------------------------
// xtkb_queue
// Byte ring queue, one slot kept free. Registered head read with
// write-through forwarding.
// ----------------------------------------------------------------------------
module xtkb_queue
    import xtkb_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  xtkb_qreq_t  req,
    output xtkb_qstat_t stat
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

    logic [7:0]    mem [DEPTH];
    logic [IW-1:0] wr_reg, rd_reg;
    logic [IW-1:0] wr_next, rd_next;
    logic [IW-1:0] waddr, raddr;
    logic [7:0]    head_reg;
    logic          full, we;

    function automatic logic [IW-1:0] nslot(input logic [IW-1:0] i);
        return (i == LAST_SLOT) ? '0 : i + 1'b1;
    endfunction

    always_comb begin
        waddr   = nslot(wr_reg);
        full    = (waddr == rd_reg);
        we      = step && req.enq && !full;
        wr_next = we ? waddr : wr_reg;
        rd_next = (step && req.deq) ? nslot(rd_reg) : rd_reg;
        raddr   = nslot(rd_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
        end else begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= req.enq_byte;
        end
        if (we && waddr == raddr) begin
            head_reg <= req.enq_byte;
        end else begin
            head_reg <= mem[raddr];
        end
    end

    assign stat.empty = (wr_reg == rd_reg);
    assign stat.full  = full;
    assign stat.last  = (nslot(rd_reg) == wr_reg);
    assign stat.head  = head_reg;

endmodule

// ===== sv/xtkb_ctrl.sv =====
// ----------------------------------------------------------------------------
// xtkb_ctrl
// Frame phase machine: handles one event per step and forms the result.
// ----------------------------------------------------------------------------
module xtkb_ctrl
    import xtkb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  logic [1:0]   operation,
    input  logic         data_line,
    input  logic [7:0]   push_byte,
    input  logic [7:0]   half_cycle_us,
    input  logic [7:0]   reset_hold_ticks,
    input  xtkb_qstat_t  qstat,
    output xtkb_qreq_t   qreq,
    output xtkb_result_t result
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_PREP_PSTART, PH_SEND_PSTART, PH_PREP_START,
        PH_SEND_START, PH_PREP_BIT, PH_SEND_BIT, PH_HOLDOFF
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] shift_reg, shift_next;
    logic [3:0] bits_reg, bits_next;
    logic [7:0] hold_reg, hold_next;
    logic       clk_reg, clk_next;
    logic       dat_reg, dat_next;
    logic [1:0] tcmd, cwatch;
    logic [7:0] tus;
    logic       accepted, enq_ok, empty_after;

    always_comb begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        bits_next  = bits_reg;
        hold_next  = hold_reg;
        clk_next   = clk_reg;
        dat_next   = dat_reg;
        tcmd       = TMR_KEEP;
        tus        = '0;
        cwatch     = WATCH_KEEP;
        accepted   = 1'b0;
        qreq       = '0;

        case (operation)
            OP_TICK: begin
                case (phase_reg)
                    PH_PREP_PSTART: begin
                        clk_next   = 1'b0;
                        phase_next = PH_SEND_PSTART;
                    end
                    PH_SEND_PSTART: begin
                        clk_next   = 1'b1;
                        dat_next   = 1'b1;
                        phase_next = PH_PREP_START;
                    end
                    PH_PREP_START: begin
                        clk_next   = 1'b0;
                        phase_next = PH_SEND_START;
                    end
                    PH_SEND_START: begin
                        clk_next   = 1'b1;
                        phase_next = PH_PREP_BIT;
                        dat_next   = qstat.head[0];
                        shift_next = {1'b0, qstat.head[7:1]};
                        bits_next  = 4'd1;
                    end
                    PH_PREP_BIT: begin
                        clk_next   = 1'b0;
                        phase_next = PH_SEND_BIT;
                    end
                    PH_SEND_BIT: begin
                        if (bits_reg == FRAME_BITS) begin
                            qreq.deq   = 1'b1;
                            dat_next   = 1'b1;
                            cwatch     = WATCH_RISING;
                            clk_next   = 1'b1;
                            phase_next = PH_HOLDOFF;
                            hold_next  = '0;
                            tcmd       = TMR_RESTART;
                            tus        = HOLDOFF_US;
                        end else begin
                            clk_next   = 1'b1;
                            phase_next = PH_PREP_BIT;
                            dat_next   = shift_reg[0];
                            shift_next = {1'b0, shift_reg[7:1]};
                            bits_next  = bits_reg + 4'd1;
                        end
                    end
                    PH_HOLDOFF: begin
                        if (hold_reg < HOLD_TICKS_MAX) begin
                            hold_next = hold_reg + 8'd1;
                        end
                    end
                    default: begin
                        tcmd = TMR_STOP;
                    end
                endcase
            end
            OP_EDGE: begin
                cwatch = WATCH_OFF;
                if (phase_reg == PH_IDLE) begin
                    cwatch     = WATCH_RISING;
                    clk_next   = 1'b1;
                    phase_next = PH_HOLDOFF;
                    hold_next  = '0;
                    tcmd       = TMR_RESTART;
                    tus        = HOLDOFF_US;
                end else if (phase_reg == PH_HOLDOFF) begin
                    tcmd          = TMR_STOP;
                    qreq.enq      = (hold_reg >= reset_hold_ticks);
                    qreq.enq_byte = RESET_REPLY;
                    phase_next    = PH_IDLE;
                    if (data_line) begin
                        if (!qstat.empty || (qreq.enq && !qstat.full)) begin
                            phase_next = PH_PREP_PSTART;
                            dat_next   = 1'b0;
                            tcmd       = TMR_RESTART;
                            tus        = half_cycle_us;
                        end else begin
                            cwatch = WATCH_FALLING;
                        end
                    end
                end
            end
            OP_PUSH: begin
                qreq.enq      = 1'b1;
                qreq.enq_byte = push_byte;
                accepted      = !qstat.full;
                if (accepted && phase_reg == PH_IDLE) begin
                    if (data_line) begin
                        phase_next = PH_PREP_PSTART;
                        dat_next   = 1'b0;
                        tcmd       = TMR_RESTART;
                        tus        = half_cycle_us;
                    end else begin
                        cwatch     = WATCH_RISING;
                        clk_next   = 1'b1;
                        phase_next = PH_HOLDOFF;
                        hold_next  = '0;
                        tcmd       = TMR_RESTART;
                        tus        = HOLDOFF_US;
                    end
                end
            end
            default: begin
            end
        endcase

        enq_ok      = qreq.enq && !qstat.full;
        empty_after = enq_ok ? 1'b0 : (qreq.deq ? qstat.last : qstat.empty);

        result.clk_level     = clk_next;
        result.data_level    = dat_next;
        result.timer_cmd     = tcmd;
        result.timer_us      = tus;
        result.clk_watch     = cwatch;
        result.push_accepted = accepted;
        result.queue_empty   = empty_after;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            shift_reg <= '0;
            bits_reg  <= '0;
            hold_reg  <= '0;
            clk_reg   <= 1'b1;
            dat_reg   <= 1'b1;
        end else if (step) begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
            hold_reg  <= hold_next;
            clk_reg   <= clk_next;
            dat_reg   <= dat_next;
        end
    end

endmodule

// ===== sv/xt_keyboard_device_transmitter_unit.sv =====
// ----------------------------------------------------------------------------
// xt_keyboard_device_transmitter_unit
// Device side of the PC/XT keyboard link with a byte queue.
// ----------------------------------------------------------------------------
// Each request on the s_ channel is one event: tuser is the event kind
// (timer tick, host clock edge, push byte), tdata carries the sampled data
// line and the byte to push. Every event yields exactly one result on the
// m_ channel: the driven clock and data levels, the timer and clock-watch
// commands, whether a push was queued and whether the queue is empty.
// A request passes from the input register through the phase machine and
// queue update into the result register. One request is taken per cycle
// while the result side moves; the input register and the result register
// decouple the two sides, so a request is taken while a result waits.
// When m_tready is low the result holds, the held request waits in the
// input register and s_tready drops until the result moves.
// The head byte of the queue is read through a registered memory port.
// Reset (aresetn low, synchronous) empties the queue, sets the phase to
// idle, both lines high and the registers to 50 us and 60 ticks.
// ----------------------------------------------------------------------------
module xt_keyboard_device_transmitter_unit
    import xtkb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_line, push_byte, zero pad
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // clk_level, data_level, timer_cmd,
                                   // timer_us, clk_watch, push_accepted,
                                   // queue_empty
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic         in_valid_reg;
    logic [1:0]   op_reg;
    logic         dline_reg;
    logic [7:0]   byte_reg;
    logic         out_valid_reg;
    xtkb_result_t out_reg;
    logic [7:0]   half_cycle_reg, hold_cfg_reg;
    logic         out_free, step;
    xtkb_qreq_t   qreq;
    xtkb_qstat_t  qstat;
    xtkb_result_t result;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_HOLD_TICKS) ? {24'd0, hold_cfg_reg}
                                                   : {24'd0, half_cycle_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_cycle_reg <= HALF_CYCLE_RESET;
            hold_cfg_reg   <= HOLD_CFG_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_HALF_CYCLE) begin
                half_cycle_reg <= pwdata[7:0];
            end else begin
                hold_cfg_reg <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg    <= s_tuser;
            dline_reg <= s_tdata[0];
            byte_reg  <= s_tdata[8:1];
        end
        if (step) begin
            out_reg <= result;
        end
    end

    xtkb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .req     (qreq),
        .stat    (qstat)
    );

    xtkb_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (step),
        .operation        (op_reg),
        .data_line        (dline_reg),
        .push_byte        (byte_reg),
        .half_cycle_us    (half_cycle_reg),
        .reset_hold_ticks (hold_cfg_reg),
        .qstat            (qstat),
        .qreq             (qreq),
        .result           (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.queue_empty, out_reg.push_accepted, out_reg.clk_watch,
                       out_reg.timer_us, out_reg.timer_cmd, out_reg.data_level,
                       out_reg.clk_level};

    a_push_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.push_accepted) |-> !out_reg.queue_empty)
        else $error("accepted push reported an empty queue");

    a_us_only_on_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.timer_cmd != TMR_RESTART) |-> (out_reg.timer_us == 8'd0))
        else $error("timer period without restart");

    a_falling_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.clk_watch == WATCH_FALLING)
            |-> (out_reg.timer_cmd == TMR_STOP && out_reg.queue_empty))
        else $error("falling watch without timer stop on empty queue");

    a_holdoff_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.clk_watch == WATCH_RISING)
            |-> (out_reg.timer_cmd == TMR_RESTART && out_reg.timer_us == HOLDOFF_US
                 && out_reg.clk_level))
        else $error("holdoff entry with wrong timer or clock level");

endmodule

// ===== tb/xt_keyboard_device_transmitter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// xt_keyboard_device_transmitter_unit_tb
// Self-checking bench for the XT keyboard device transmitter.
// ----------------------------------------------------------------------------
// Drives timer ticks, host clock edges and byte pushes as stream requests and
// tracks the link in a local copy of the phase machine and byte queue.
// Every result is compared field by field against that prediction. Runs a
// short directed sequence, then full frames with random holdoff lengths and
// random noise under several register settings and idle/stall mixes, plus a
// long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module xt_keyboard_device_transmitter_unit_tb;
    import xtkb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         LONG_STALL  = 300;
    localparam int         CYCLE_LIMIT = 600000;

    typedef enum logic [2:0] {
        P_IDLE, P_PSTART_SET, P_PSTART_CLK, P_START_SET,
        P_START_CLK, P_BIT_SET, P_BIT_CLK, P_HOLDOFF
    } link_phase_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // data_line, push_byte, zero pad
    logic [1:0]  s_tuser  = '0;   // operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // clk_level, data_level, timer_cmd, timer_us,
                                  // clk_watch, push_accepted, queue_empty
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // link model state
    link_phase_t  kb_phase = P_IDLE;
    logic [7:0]   kb_shift = '0;
    logic [3:0]   kb_bits  = '0;
    logic [7:0]   kb_hold  = '0;
    logic [7:0]   kb_fifo [16];
    logic [3:0]   kb_wr    = '0;
    logic [3:0]   kb_rd    = '0;
    logic         kb_clk   = 1'b1;
    logic         kb_data  = 1'b1;
    logic [7:0]   cfg_half = HALF_CYCLE_RESET;
    logic [7:0]   cfg_hold = HOLD_CFG_RESET;
    xtkb_result_t kb_out;

    xtkb_result_t pending_results[$];
    int           errors       = 0;
    int           cycle_count  = 0;
    int           tx_idle_pct  = 0;
    int           rx_stall_pct = 0;
    int           stall_req    = 0;
    int           stall_seen   = 0;
    int           stall_left   = 0;

    xt_keyboard_device_transmitter_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Link prediction
    // ------------------------------------------------------------------------
    function automatic void go_holdoff();
        kb_out.clk_watch = WATCH_RISING;
        kb_clk           = 1'b1;
        kb_phase         = P_HOLDOFF;
        kb_hold          = '0;
        kb_out.timer_cmd = TMR_RESTART;
        kb_out.timer_us  = HOLDOFF_US;
    endfunction

    function automatic void open_frame(logic dl);
        if (!dl) begin
            go_holdoff();
        end else begin
            kb_phase         = P_PSTART_SET;
            kb_data          = 1'b0;
            kb_out.timer_cmd = TMR_RESTART;
            kb_out.timer_us  = cfg_half;
        end
    endfunction

    function automatic void shift_out();
        kb_phase = P_BIT_SET;
        kb_data  = kb_shift[0];
        kb_shift = kb_shift >> 1;
        kb_bits  = kb_bits + 4'd1;
    endfunction

    function automatic logic queue_byte(logic [7:0] b);
        logic [3:0] nxt;
        nxt = kb_wr + 4'd1;
        if (nxt == kb_rd) return 1'b0;
        kb_fifo[nxt] = b;
        kb_wr = nxt;
        return 1'b1;
    endfunction

    function automatic void stop_timer();
        kb_out.timer_cmd = TMR_STOP;
        kb_out.timer_us  = '0;
    endfunction

    function automatic xtkb_result_t predict_event(logic [1:0] op, logic dl, logic [7:0] b);
        kb_out = '0;
        case (op)
            OP_TICK: begin
                case (kb_phase)
                    P_PSTART_SET: begin
                        kb_clk   = 1'b0;
                        kb_phase = P_PSTART_CLK;
                    end
                    P_PSTART_CLK: begin
                        kb_clk   = 1'b1;
                        kb_data  = 1'b1;
                        kb_phase = P_START_SET;
                    end
                    P_START_SET: begin
                        kb_clk   = 1'b0;
                        kb_phase = P_START_CLK;
                    end
                    P_START_CLK: begin
                        kb_bits  = '0;
                        kb_shift = kb_fifo[kb_rd + 4'd1];
                        kb_clk   = 1'b1;
                        shift_out();
                    end
                    P_BIT_SET: begin
                        kb_clk   = 1'b0;
                        kb_phase = P_BIT_CLK;
                    end
                    P_BIT_CLK: begin
                        if (kb_bits == FRAME_BITS) begin
                            kb_rd   = kb_rd + 4'd1;
                            kb_data = 1'b1;
                            go_holdoff();
                        end else begin
                            kb_clk = 1'b1;
                            shift_out();
                        end
                    end
                    P_HOLDOFF: begin
                        if (kb_hold < HOLD_TICKS_MAX) kb_hold = kb_hold + 8'd1;
                    end
                    default: begin
                        stop_timer();
                    end
                endcase
            end
            OP_EDGE: begin
                kb_out.clk_watch = WATCH_OFF;
                if (kb_phase == P_IDLE) begin
                    go_holdoff();
                end else if (kb_phase == P_HOLDOFF) begin
                    stop_timer();
                    if (kb_hold >= cfg_hold) void'(queue_byte(RESET_REPLY));
                    if (!dl) begin
                        kb_phase = P_IDLE;
                    end else if (kb_wr != kb_rd) begin
                        open_frame(1'b1);
                    end else begin
                        kb_phase = P_IDLE;
                        stop_timer();
                        kb_out.clk_watch = WATCH_FALLING;
                    end
                end
            end
            OP_PUSH: begin
                if (queue_byte(b)) begin
                    kb_out.push_accepted = 1'b1;
                    if (kb_phase == P_IDLE) open_frame(dl);
                end
            end
            default: ;
        endcase
        kb_out.clk_level   = kb_clk;
        kb_out.data_level  = kb_data;
        kb_out.queue_empty = (kb_wr == kb_rd);
        return kb_out;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor and checker
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        xtkb_result_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = xtkb_result_t'(m_tdata);
                if (pending_results.size() == 0) begin
                    $error("result 0x%h with no request pending", m_tdata);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("clk_level", 8'(want.clk_level), 8'(got.clk_level));
                    check_field("data_level", 8'(want.data_level), 8'(got.data_level));
                    check_field("timer_cmd", 8'(want.timer_cmd), 8'(got.timer_cmd));
                    check_field("timer_us", want.timer_us, got.timer_us);
                    check_field("clk_watch", 8'(want.clk_watch), 8'(got.clk_watch));
                    check_field("push_accepted", 8'(want.push_accepted),
                                8'(got.push_accepted));
                    check_field("queue_empty", 8'(want.queue_empty), 8'(got.queue_empty));
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(predict_event(s_tuser, s_tdata[0], s_tdata[8:1]));
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (stall_seen != stall_req) begin
            stall_seen <= stall_req;
            stall_left <= LONG_STALL;
            m_tready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_event(logic [1:0] op, logic dl, logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, b, dl};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_HALF_CYCLE) cfg_half = val;
        else cfg_hold = val;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic random_traffic(int n_items);
        int done, kind, k;
        done = 0;
        while (done < n_items) begin
            kind = $urandom_range(9);
            if (kind < 5) begin
                // whole frame, holdoff of random length, then the host edge
                send_event(OP_PUSH, 1'b1, 8'($urandom));
                repeat (20) send_event(OP_TICK, 1'($urandom), 8'($urandom));
                k = ($urandom_range(3) == 0) ? $urandom_range(300)
                                             : $urandom_range(int'(cfg_hold) + 4);
                repeat (k) send_event(OP_TICK, 1'($urandom), 8'($urandom));
                send_event(OP_EDGE, ($urandom_range(9) != 0), 8'($urandom));
                done += k + 22;
            end else if (kind < 8) begin
                k = $urandom_range(1, 8);
                repeat (k) send_event(2'($urandom_range(2)), 1'($urandom), 8'($urandom));
                done += k;
            end else begin
                k = $urandom_range(4, 18);
                repeat (k) send_event(OP_PUSH, 1'($urandom), 8'($urandom));
                done += k;
            end
        end
    endtask

    task automatic traffic_phase(logic [7:0] half, logic [7:0] hold, int txp, int rxp,
                                 int n_items);
        drain();
        write_reg(REG_HALF_CYCLE, half);
        write_reg(REG_HOLD_TICKS, hold);
        tx_idle_pct  = txp;
        rx_stall_pct = rxp;
        random_traffic(n_items);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_events();
        drain();
        write_reg(REG_HALF_CYCLE, 8'd255);
        write_reg(REG_HOLD_TICKS, 8'd0);
        send_event(OP_UNUSED, 1'b1, 8'hFF);
        send_event(OP_TICK, 1'b0, 8'h00);     // tick while idle stops the timer
        send_event(OP_EDGE, 1'b1, 8'h00);     // edge while idle enters holdoff
        send_event(OP_TICK, 1'b1, 8'hFF);
        send_event(OP_EDGE, 1'b0, 8'h00);     // host holds data low: back to idle
        send_event(OP_PUSH, 1'b0, 8'h00);     // push with data low goes to holdoff
        repeat (15) send_event(OP_PUSH, 1'b1, 8'hFF);  // fills up, last two refused
        send_event(OP_EDGE, 1'b1, 8'h55);     // reply dropped, frame starts
        send_event(OP_TICK, 1'b0, 8'hAA);
        send_event(OP_TICK, 1'b1, 8'h00);
        send_event(OP_EDGE, 1'b0, 8'hFF);     // edge mid-frame only turns watch off
        send_event(OP_TICK, 1'b0, 8'h00);
    endtask

    task automatic test_no_idling();
        traffic_phase(8'd1, 8'd254, 0, 0, 460);
    endtask

    task automatic test_sender_idle();
        traffic_phase(8'd0, 8'd1, 83, 0, 460);
    endtask

    task automatic test_receiver_stall();
        traffic_phase(HALF_CYCLE_RESET, HOLD_CFG_RESET, 0, 83, 460);
    endtask

    task automatic test_both_idle();
        traffic_phase(8'($urandom_range(1, 255)), 8'($urandom_range(254)), 20, 20, 460);
    endtask

    task automatic test_backpressure();
        drain();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        stall_req++;
        random_traffic(80);
    endtask

    initial begin
        foreach (kb_fifo[i]) kb_fifo[i] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_events();
        test_no_idling();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_backpressure();
        drain();
        repeat (10) @(posedge aclk);
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
sv/xtkb_pkg.sv
sv/xtkb_queue.sv
sv/xtkb_ctrl.sv
sv/xt_keyboard_device_transmitter_unit.sv
tb/xt_keyboard_device_transmitter_unit_tb.sv
